@@ hdl/ndr_pkg.sv @@
// Package with the shared types and constants of the data run decoder.
`timescale 1ns / 1ps
package ndr_pkg;

  localparam int unsigned MAX_FIELD_BYTES = 8;
  localparam logic [3:0] NIBBLE_MAX = 4'(MAX_FIELD_BYTES);

  typedef enum logic [1:0] {
    KIND_RUN    = 2'd0,
    KIND_SPARSE = 2'd1,
    KIND_END    = 2'd2,
    KIND_BAD    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_OFFSET = 2'd2,
    PH_IGNORE = 2'd3
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] len;
    logic [63:0] off;
    logic [63:0] total;
    logic        ovf;
  } result_t;

endpackage

@@ hdl/ndr_if.sv @@
// Valid/ready channel interfaces for run list bytes and decoded run items.
`timescale 1ns / 1ps
interface ndr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       list_start;

  modport source (output valid, output data_byte, output list_start, input ready);
  modport sink (input valid, input data_byte, input list_start, output ready);
endinterface

interface ndr_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         item_kind;
  logic [63:0]        cluster_count;
  logic signed [63:0] cluster_delta;
  logic [63:0]        total_clusters;
  logic               total_overflow;

  modport source (output valid, output item_kind, output cluster_count, output cluster_delta,
                  output total_clusters, output total_overflow, input ready);
  modport sink (input valid, input item_kind, input cluster_count, input cluster_delta,
                input total_clusters, input total_overflow, output ready);
endinterface

@@ hdl/ntfs_data_run_decoder.sv @@
// Top level of the data run list decoder: input register, decode step, result register.
// The last byte of an item passes the input register, and its result beat the result register.
// Throughput: one run list byte per cycle; while a result waits to be taken, bytes that
// complete no item keep flowing and a byte that completes one waits in the input register.
// Reset: synchronous; the decoder expects a header, the total is zero and both
// registers are empty.
`timescale 1ns / 1ps
module ntfs_data_run_decoder
  import ndr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ndr_in_if.sink    run_bytes,
  ndr_out_if.source run_items
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_start;
  logic       s1_go;
  logic       out_free;
  logic       emit;
  result_t    step_result;
  logic       out_valid;
  result_t    out_result;

  assign out_free        = !out_valid || run_items.ready;
  assign s1_go           = s1_valid && (out_free || !emit);
  assign run_bytes.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (run_bytes.ready) begin
      s1_valid <= run_bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (run_bytes.ready && run_bytes.valid) begin
      s1_byte  <= run_bytes.data_byte;
      s1_start <= run_bytes.list_start;
    end
  end

  ndr_step u_step (
    .clk        (clk),
    .rst        (rst),
    .en         (s1_go),
    .data_byte  (s1_byte),
    .list_start (s1_start),
    .emit       (emit),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_go && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_go && emit) begin
      out_result <= step_result;
    end
  end

  assign run_items.valid          = out_valid;
  assign run_items.item_kind      = out_result.kind;
  assign run_items.cluster_count  = out_result.len;
  assign run_items.cluster_delta  = $signed(out_result.off);
  assign run_items.total_clusters = out_result.total;
  assign run_items.total_overflow = out_result.ovf;

  a_total_only_at_end : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.kind != KIND_END |-> out_result.total == 64'd0 && !out_result.ovf)
    else $error("total reported on a beat that is not an end of list");

  a_sparse_zero_offset : assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_result.kind == KIND_SPARSE || out_result.kind == KIND_BAD)
    |-> out_result.off == 64'd0)
    else $error("nonzero offset on a sparse or malformed beat");

  a_held_byte_kept : assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_byte) && $stable(s1_start))
    else $error("stalled input byte was lost or changed");

  a_reset_empties : assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("registers not empty after reset");

endmodule

@@ hdl/ndr_step.sv @@
// Decoder state and the per-byte next-state and result logic.
`timescale 1ns / 1ps
module ndr_step
  import ndr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [7:0] data_byte,
  input  logic       list_start,
  output logic       emit,
  output result_t    result
);

  phase_t      phase, phase_next;
  logic [3:0]  len_left, len_left_next;
  logic [3:0]  off_left, off_left_next;
  logic [2:0]  pos, pos_next;
  logic [63:0] len_acc, len_acc_next;
  logic [63:0] off_acc, off_acc_next;
  logic [63:0] total, total_next;
  logic        ovf, ovf_next;

  phase_t      phase_eff;
  logic [63:0] total_eff;
  logic        ovf_eff;
  logic [63:0] lane_byte;
  logic [63:0] len_or;
  logic [63:0] off_or;
  logic [63:0] off_ext;
  logic [63:0] len_fin;
  logic [64:0] sum;
  logic [3:0]  lsz;
  logic [3:0]  osz;
  logic        finish;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      lane_byte[8*i +: 8] = (pos == 3'(i)) ? data_byte : 8'h00;
    end
    len_or = len_acc | lane_byte;
    off_or = off_acc | lane_byte;
    // The last offset byte carries the sign; lanes above it take its sign bit.
    for (int i = 0; i < 8; i++) begin
      off_ext[8*i +: 8] = (3'(i) > pos) ? {8{data_byte[7]}} : off_or[8*i +: 8];
    end
  end

  assign phase_eff = list_start ? PH_HEADER : phase;
  assign total_eff = list_start ? 64'd0 : total;
  assign ovf_eff   = list_start ? 1'b0 : ovf;
  assign lsz       = data_byte[3:0];
  assign osz       = data_byte[7:4];
  assign len_fin   = (phase_eff == PH_LENGTH) ? len_or : len_acc;
  assign sum       = {1'b0, total_eff} + {1'b0, len_fin};

  always_comb begin
    phase_next    = phase_eff;
    len_left_next = len_left;
    off_left_next = off_left;
    pos_next      = pos;
    len_acc_next  = len_acc;
    off_acc_next  = off_acc;
    total_next    = total_eff;
    ovf_next      = ovf_eff;
    emit          = 1'b0;
    finish        = 1'b0;
    result        = '0;
    unique case (phase_eff)
      PH_HEADER: begin
        if (data_byte == 8'h00) begin
          emit         = 1'b1;
          result.kind  = KIND_END;
          result.total = total_eff;
          result.ovf   = ovf_eff;
          phase_next   = PH_IGNORE;
        end else if (lsz == 4'd0 || lsz > NIBBLE_MAX || osz > NIBBLE_MAX) begin
          emit        = 1'b1;
          result.kind = KIND_BAD;
          phase_next  = PH_IGNORE;
        end else begin
          len_left_next = lsz;
          off_left_next = osz;
          pos_next      = 3'd0;
          len_acc_next  = 64'd0;
          off_acc_next  = 64'd0;
          phase_next    = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        len_acc_next  = len_or;
        pos_next      = pos + 3'd1;
        len_left_next = len_left - 4'd1;
        if (len_left_next == 4'd0) begin
          pos_next = 3'd0;
          if (off_left == 4'd0) begin
            finish      = 1'b1;
            result.kind = KIND_SPARSE;
          end else begin
            phase_next = PH_OFFSET;
          end
        end
      end
      PH_OFFSET: begin
        off_acc_next  = off_or;
        pos_next      = pos + 3'd1;
        off_left_next = off_left - 4'd1;
        if (off_left_next == 4'd0) begin
          finish      = 1'b1;
          result.kind = KIND_RUN;
          result.off  = off_ext;
        end
      end
      PH_IGNORE: begin
      end
      default: begin
      end
    endcase
    if (finish) begin
      emit       = 1'b1;
      result.len = len_fin;
      phase_next = PH_HEADER;
      if (sum[64]) begin
        total_next = '1;
        ovf_next   = 1'b1;
      end else begin
        total_next = sum[63:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      len_left <= 4'd0;
      off_left <= 4'd0;
      pos      <= 3'd0;
      len_acc  <= 64'd0;
      off_acc  <= 64'd0;
      total    <= 64'd0;
      ovf      <= 1'b0;
    end else if (en) begin
      phase    <= phase_next;
      len_left <= len_left_next;
      off_left <= off_left_next;
      pos      <= pos_next;
      len_acc  <= len_acc_next;
      off_acc  <= off_acc_next;
      total    <= total_next;
      ovf      <= ovf_next;
    end
  end

endmodule

@@ dv/ndr_run_checker.sv @@
// Checker that predicts the decoded run items from the accepted bytes and compares the result beats.
`timescale 1ns / 1ps
module ndr_run_checker
  import ndr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ndr_in_if    run_bytes,
  ndr_out_if   run_items,
  output int   mismatches,
  output int   outstanding,
  output int   results_checked,
  output int   saturated_ends
);

  phase_t      phase;
  logic [3:0]  len_left;
  logic [3:0]  off_left;
  logic [3:0]  off_size;
  logic [2:0]  byte_pos;
  logic [63:0] len_acc;
  logic [63:0] off_acc;
  logic [63:0] total_acc;
  logic        total_sat;
  result_t     predicted_items[$];

  task automatic clear_decoder();
    phase     = PH_HEADER;
    len_left  = '0;
    off_left  = '0;
    off_size  = '0;
    byte_pos  = '0;
    len_acc   = '0;
    off_acc   = '0;
    total_acc = '0;
    total_sat = 1'b0;
  endtask

  task automatic close_run();
    logic [64:0] sum;
    logic [63:0] mask;
    logic [63:0] off;
    result_t     item;
    sum = {1'b0, total_acc} + {1'b0, len_acc};
    if (sum[64]) begin
      total_acc = '1;
      total_sat = 1'b1;
    end else begin
      total_acc = sum[63:0];
    end
    item = '0;
    item.len = len_acc;
    if (off_size == 0) begin
      item.kind = KIND_SPARSE;
    end else begin
      item.kind = KIND_RUN;
      off = off_acc;
      if (off_size < NIBBLE_MAX) begin
        mask = (64'd1 << (8 * off_size)) - 64'd1;
        off = off & mask;
        if (off[8 * off_size - 1]) begin
          off = off | ~mask;
        end
      end
      item.off = off;
    end
    predicted_items.push_back(item);
    phase = PH_HEADER;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic start);
    logic [3:0] lsz;
    logic [3:0] osz;
    result_t    item;
    lsz = b[3:0];
    osz = b[7:4];
    item = '0;
    if (start) begin
      phase = PH_HEADER;
      total_acc = '0;
      total_sat = 1'b0;
    end
    case (phase)
      PH_HEADER: begin
        if (b == 8'd0) begin
          item.kind = KIND_END;
          item.total = total_acc;
          item.ovf = total_sat;
          predicted_items.push_back(item);
          phase = PH_IGNORE;
        end else if (lsz == 0 || lsz > NIBBLE_MAX || osz > NIBBLE_MAX) begin
          item.kind = KIND_BAD;
          predicted_items.push_back(item);
          phase = PH_IGNORE;
        end else begin
          len_left = lsz;
          off_left = osz;
          off_size = osz;
          byte_pos = '0;
          len_acc = '0;
          off_acc = '0;
          phase = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        len_acc = len_acc | (64'(b) << (8 * byte_pos));
        byte_pos = byte_pos + 3'd1;
        len_left = len_left - 4'd1;
        if (len_left == 0) begin
          byte_pos = '0;
          if (off_left == 0) begin
            close_run();
          end else begin
            phase = PH_OFFSET;
          end
        end
      end
      PH_OFFSET: begin
        off_acc = off_acc | (64'(b) << (8 * byte_pos));
        byte_pos = byte_pos + 3'd1;
        off_left = off_left - 4'd1;
        if (off_left == 0) begin
          close_run();
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      if (mismatches < 10) begin
        $display("Beat %0d: %s expected %h, got %h", results_checked, field, want, got);
      end
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_decoder();
      predicted_items.delete();
      outstanding <= 0;
    end else begin
      if (run_items.valid && run_items.ready) begin
        if (predicted_items.size() == 0) begin
          if (mismatches < 10) begin
            $display("Beat %0d: unexpected result, kind %0d", results_checked,
                     run_items.item_kind);
          end
          mismatches++;
        end else begin
          want = predicted_items.pop_front();
          check_field("item_kind", 64'(want.kind), 64'(run_items.item_kind));
          check_field("cluster_count", want.len, run_items.cluster_count);
          check_field("cluster_delta", want.off, run_items.cluster_delta);
          check_field("total_clusters", want.total, run_items.total_clusters);
          check_field("total_overflow", 64'(want.ovf), 64'(run_items.total_overflow));
          if (want.kind == KIND_END && want.ovf) begin
            saturated_ends++;
          end
        end
        results_checked++;
      end
      if (run_bytes.valid && run_bytes.ready) begin
        decode_byte(run_bytes.data_byte, run_bytes.list_start);
      end
      outstanding <= predicted_items.size();
    end
  end

endmodule

@@ dv/ntfs_data_run_decoder_tb.sv @@
// Testbench top for the data run list decoder: clock, reset, byte stimulus, result stalls, verdict.
`timescale 1ns / 1ps
module ntfs_data_run_decoder_tb;

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   results_checked;
  int   saturated_ends;
  int   bytes_sent;
  int   hold_cycles;
  int   gap_pct;
  bit   quiet;
  bit   start_next;

  ndr_in_if  bytes_if();
  ndr_out_if items_if();

  ntfs_data_run_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .run_bytes (bytes_if),
    .run_items (items_if)
  );

  ndr_run_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .run_bytes       (bytes_if),
    .run_items       (items_if),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .saturated_ends  (saturated_ends)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int n;
    items_if.ready <= 1'b0;
    forever begin
      if (hold_cycles != 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        items_if.ready <= 1'b0;
      end else if (quiet) begin
        n = 1;
        items_if.ready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 10);
        items_if.ready <= 1'b0;
      end else begin
        n = $urandom_range(1, 20);
        items_if.ready <= 1'b1;
      end
      repeat (n) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic s);
    bytes_if.valid <= 1'b1;
    bytes_if.data_byte <= b;
    bytes_if.list_start <= s;
    do @(posedge clk); while (!bytes_if.ready);
  endtask

  task automatic sender_gap(input int n);
    bytes_if.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_list_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      sender_gap($urandom_range(1, 10));
    end
    send_byte(b, start_next);
    start_next = 1'b0;
    bytes_sent++;
  endtask

  task automatic send_run(input logic [3:0] lsz, input logic [3:0] osz,
                          input logic [63:0] len_val, input logic [63:0] off_val);
    send_list_byte({osz, lsz});
    for (int i = 0; i < lsz; i++) send_list_byte(len_val[8 * i +: 8]);
    for (int i = 0; i < osz; i++) send_list_byte(off_val[8 * i +: 8]);
  endtask

  task automatic wait_drained();
    bytes_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic send_random_list();
    int          runs;
    bit          big;
    logic [3:0]  lsz;
    logic [3:0]  osz;
    logic [63:0] len_val;
    logic [63:0] off_val;
    case ($urandom_range(0, 3))
      0, 1: gap_pct = 0;
      2: gap_pct = 15;
      default: gap_pct = 40;
    endcase
    start_next = 1'b1;
    big = ($urandom_range(0, 7) == 0);
    runs = $urandom_range(1, 6);
    repeat (runs) begin
      if (big) lsz = 4'd8;
      else if ($urandom_range(0, 3) == 0) lsz = 4'($urandom_range(4, 8));
      else lsz = 4'($urandom_range(1, 3));
      if ($urandom_range(0, 4) == 0) osz = 4'd0;
      else if ($urandom_range(0, 3) == 0) osz = 4'($urandom_range(5, 8));
      else osz = 4'($urandom_range(1, 4));
      len_val = {$urandom, $urandom};
      off_val = {$urandom, $urandom};
      if (big) len_val[63] = 1'b1;
      send_run(lsz, osz, len_val, off_val);
    end
    send_list_byte(8'd0);
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    end
  endtask

  task automatic send_noise_list();
    start_next = 1'b1;
    if ($urandom_range(0, 1) == 0) begin
      send_list_byte({4'($urandom_range(0, 8)), 4'($urandom_range(1, 8))});
    end else begin
      send_list_byte(8'($urandom));
    end
    repeat ($urandom_range(0, 6)) send_byte(8'($urandom), 1'b0);
  endtask

  initial begin
    rst <= 1'b1;
    bytes_if.valid <= 1'b0;
    bytes_if.data_byte <= '0;
    bytes_if.list_start <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    gap_pct = 20;
    send_run(4'd1, 4'd1, 64'h05, 64'h80);
    send_list_byte(8'h00);
    send_list_byte(8'h21);
    start_next = 1'b1;
    send_run(4'd1, 4'd8, 64'h01, 64'h8000_0000_0000_0000);
    send_run(4'd8, 4'd0, '1, '0);
    send_list_byte(8'h00);
    start_next = 1'b1;
    send_list_byte(8'h10);
    send_list_byte(8'h11);
    start_next = 1'b1;
    send_list_byte(8'h09);
    start_next = 1'b1;
    send_list_byte(8'h91);
    start_next = 1'b1;
    send_list_byte(8'h31);
    send_list_byte(8'h02);
    start_next = 1'b1;
    send_list_byte(8'h00);
    wait_drained();

    hold_cycles = 120;
    while (bytes_sent < 1800) begin
      if ($urandom_range(0, 99) < 15) send_noise_list();
      else send_random_list();
      if (bytes_sent >= 1500) quiet = 1'b1;
    end

    wait_drained();
    repeat (16) @(posedge clk);
    $display("Run covered %0d list bytes and %0d result beats, %0d of them saturated totals.",
             bytes_sent, results_checked, saturated_ends);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ ntfs_data_run_decoder.f @@
hdl/ndr_pkg.sv
hdl/ndr_if.sv
hdl/ndr_step.sv
hdl/ntfs_data_run_decoder.sv
dv/ndr_run_checker.sv
dv/ntfs_data_run_decoder_tb.sv
